@@ rtl/acfp_pkg.sv @@
// ----------------------------------------------------------------------------
// acfp_pkg: shared types, tokens and helpers for the command frame parser
// Holds the status codes, the frame tokens, the command name table, the
// result record passed from the parser core to the top level, and the
// byte-wise CRC-32 and digit decode helpers.
// ----------------------------------------------------------------------------
package acfp_pkg;

  // Final status codes of a frame.
  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_NO_START     = 4'd1,
    ST_UNKNOWN_CMD  = 4'd2,
    ST_LEN_TERM     = 4'd3,
    ST_LEN_DIGIT    = 4'd4,
    ST_CRC_TERM     = 4'd5,
    ST_CRC_HEX      = 4'd6,
    ST_CRC_MISMATCH = 4'd7,
    ST_NO_END       = 4'd8
  } acfp_status_t;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam int NUM_CMDS = 7;
  localparam int TOK_LEN  = 6;
  localparam int END_LEN  = 3;

  // Fixed field positions within a frame.
  localparam logic [10:0] POS_CMD     = 11'd6;
  localparam logic [10:0] POS_LEN     = 11'd12;
  localparam logic [10:0] POS_LEN_END = 11'd15;
  localparam logic [10:0] POS_PAYLOAD = 11'd16;
  localparam logic [10:0] HEX_DIGITS  = 11'd8;

  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  localparam logic [7:0] START_TOK [TOK_LEN] = '{"S", "T", "A", "R", "T", ";"};
  localparam logic [7:0] END_TOK [END_LEN] = '{"E", "N", "D"};

  localparam logic [7:0] CMD_NAMES [NUM_CMDS][TOK_LEN] = '{
    '{"S", "H", "U", "T", "D", ";"},
    '{"R", "I", "N", "I", "T", ";"},
    '{"D", "C", "O", "N", "F", ";"},
    '{"C", "O", "N", "N", "C", ";"},
    '{"A", "S", "Y", "N", "C", ";"},
    '{"U", "I", "C", "O", "N", ";"},
    '{"S", "L", "P", "O", "S", ";"}
  };

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // One result produced by the parser core for one accepted byte.
  typedef struct packed {
    logic         valid;
    logic         result_kind;
    logic [7:0]   payload_byte;
    acfp_status_t status;
    logic [2:0]   command_type;
    logic [9:0]   payload_length;
    logic [31:0]  received_crc;
  } acfp_result_t;

  // Reflected CRC-32 update with one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Decimal digit check.
  function automatic logic is_dec(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, b[3:0]};
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

@@ rtl/acfp_in_if.sv @@
// ----------------------------------------------------------------------------
// acfp_in_if: input byte channel of the command frame parser
// Carries one message byte and its start-of-message mark per transaction.
// ----------------------------------------------------------------------------
interface acfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ rtl/acfp_out_if.sv @@
// ----------------------------------------------------------------------------
// acfp_out_if: result channel of the command frame parser
// Carries either one payload byte or the final frame status per transaction.
// ----------------------------------------------------------------------------
interface acfp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [3:0]  status;
  logic [2:0]  command_type;
  logic [9:0]  payload_length;
  logic [31:0] received_crc;

  modport source (output valid, output result_kind, output payload_byte, output status,
                  output command_type, output payload_length, output received_crc,
                  input ready);
  modport sink (input valid, input result_kind, input payload_byte, input status,
                input command_type, input payload_length, input received_crc,
                output ready);
endinterface

@@ rtl/acfp_parser.sv @@
// ----------------------------------------------------------------------------
// acfp_parser: frame state and per-byte parsing step
// Holds the frame state registers and computes, for each accepted byte, the
// next state and the result it causes, if any, in a single pass.
// ----------------------------------------------------------------------------
module acfp_parser
  import acfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         frame_start,
  output acfp_result_t res
);

  // Frame state registers.
  logic [10:0] byte_position;
  logic [6:0]  command_match_mask;
  logic [9:0]  length_accumulator;
  logic [31:0] running_crc;
  logic [31:0] hex_accumulator;
  logic        digit_error_flag;
  logic        frame_done;
  logic [2:0]  matched_command;

  logic [10:0] byte_position_next;
  logic [6:0]  command_match_mask_next;
  logic [9:0]  length_accumulator_next;
  logic [31:0] running_crc_next;
  logic [31:0] hex_accumulator_next;
  logic        digit_error_flag_next;
  logic        frame_done_next;
  logic [2:0]  matched_command_next;

  // Effective state seen by this byte (a start mark restarts the frame).
  logic [10:0] pos;
  logic [6:0]  mask;
  logic [9:0]  len;
  logic [31:0] crc;
  logic [31:0] hex;
  logic        derr;
  logic        done;
  logic [2:0]  mcmd;

  logic [31:0]  crc_fed;
  logic [10:0]  pay_end;
  logic [10:0]  crc_term_pos;
  logic [10:0]  end_pos;
  logic [10:0]  cmd_off;
  logic [10:0]  end_off;
  logic [13:0]  len_mul;
  logic [4:0]   hex_dig;
  logic         fin;
  acfp_status_t fin_st;
  logic         have_cmd;
  logic         have_len;
  logic         have_crc;

  // Select the state that this byte works on.
  always_comb begin
    if (frame_start) begin
      pos  = 11'd0;
      mask = '1;
      len  = 10'd0;
      crc  = CRC_INIT;
      hex  = 32'd0;
      derr = 1'b0;
      done = 1'b0;
      mcmd = 3'd0;
    end else begin
      pos  = byte_position;
      mask = command_match_mask;
      len  = length_accumulator;
      crc  = running_crc;
      hex  = hex_accumulator;
      derr = digit_error_flag;
      done = frame_done;
      mcmd = matched_command;
    end
  end

  // CRC feed, digit decode and the field boundaries that depend on the decoded length.
  assign crc_fed      = crc_byte(crc, data_byte);
  assign pay_end      = POS_PAYLOAD + {1'b0, len};
  assign crc_term_pos = pay_end + HEX_DIGITS + 11'd1;
  assign end_pos      = crc_term_pos + 11'd1;
  assign cmd_off      = pos - POS_CMD;
  assign end_off      = pos - end_pos;
  assign len_mul      = {1'b0, len, 3'b000} + {3'b000, len, 1'b0} + {10'd0, data_byte[3:0]};
  assign hex_dig      = hex_decode(data_byte);

  // Parsing step: next state and the terminating status, if any.
  always_comb begin
    byte_position_next      = pos + 11'd1;
    command_match_mask_next = mask;
    length_accumulator_next = len;
    running_crc_next        = crc;
    hex_accumulator_next    = hex;
    digit_error_flag_next   = derr;
    frame_done_next         = done;
    matched_command_next    = mcmd;
    fin                     = 1'b0;
    fin_st                  = ST_OK;

    if (!done) begin
      if (pos < POS_CMD) begin
        running_crc_next = crc_fed;
        if (data_byte != START_TOK[pos[2:0]]) begin
          fin    = 1'b1;
          fin_st = ST_NO_START;
        end
      end else if (pos < POS_LEN) begin
        running_crc_next = crc_fed;
        for (int k = 0; k < NUM_CMDS; k++) begin
          command_match_mask_next[k] = mask[k] & (CMD_NAMES[k][cmd_off[2:0]] == data_byte);
        end
        if (command_match_mask_next == 7'd0) begin
          fin    = 1'b1;
          fin_st = ST_UNKNOWN_CMD;
        end else if (pos == POS_LEN - 11'd1) begin
          // The lowest matching name wins.
          for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (command_match_mask_next[k]) begin
              matched_command_next = 3'(k);
            end
          end
        end
      end else if (pos < POS_LEN_END) begin
        running_crc_next = crc_fed;
        if (is_dec(data_byte)) begin
          length_accumulator_next = len_mul[9:0];
        end else begin
          digit_error_flag_next = 1'b1;
        end
      end else if (pos == POS_LEN_END) begin
        running_crc_next = crc_fed;
        if (data_byte != CHAR_SEMI) begin
          fin    = 1'b1;
          fin_st = ST_LEN_TERM;
        end else if (derr) begin
          fin    = 1'b1;
          fin_st = ST_LEN_DIGIT;
        end else begin
          digit_error_flag_next = 1'b0;
        end
      end else if (pos <= pay_end) begin
        // Payload bytes and the unchecked separator are covered by the CRC.
        running_crc_next = crc_fed;
      end else if (pos < crc_term_pos) begin
        if (!hex_dig[4]) begin
          digit_error_flag_next = 1'b1;
        end else begin
          hex_accumulator_next = {hex[27:0], hex_dig[3:0]};
        end
      end else if (pos == crc_term_pos) begin
        if (data_byte != CHAR_SEMI) begin
          fin    = 1'b1;
          fin_st = ST_CRC_TERM;
        end else if (derr) begin
          fin    = 1'b1;
          fin_st = ST_CRC_HEX;
        end else if (~crc != hex) begin
          fin    = 1'b1;
          fin_st = ST_CRC_MISMATCH;
        end
      end else begin
        if (data_byte != END_TOK[end_off[1:0]]) begin
          fin    = 1'b1;
          fin_st = ST_NO_END;
        end else if (end_off[1:0] == 2'(END_LEN - 1)) begin
          fin    = 1'b1;
          fin_st = ST_OK;
        end
      end
      if (fin) begin
        frame_done_next = 1'b1;
      end
    end
  end

  // Which recorded fields a status carries.
  always_comb begin
    have_cmd = (fin_st != ST_NO_START) && (fin_st != ST_UNKNOWN_CMD);
    have_len = have_cmd && (fin_st != ST_LEN_TERM) && (fin_st != ST_LEN_DIGIT);
    have_crc = (fin_st == ST_CRC_MISMATCH) || (fin_st == ST_NO_END) || (fin_st == ST_OK);
  end

  // Result of this byte.
  always_comb begin
    res = '0;
    if (!done) begin
      if (fin) begin
        res.valid          = 1'b1;
        res.result_kind    = KIND_STATUS;
        res.status         = fin_st;
        res.command_type   = have_cmd ? mcmd : 3'd0;
        res.payload_length = have_len ? len : 10'd0;
        res.received_crc   = have_crc ? hex : 32'd0;
      end else if (pos > POS_LEN_END && pos < pay_end) begin
        res.valid          = 1'b1;
        res.result_kind    = KIND_PAYLOAD;
        res.payload_byte   = data_byte;
        res.status         = ST_OK;
        res.command_type   = mcmd;
        res.payload_length = len;
      end
    end
  end

  // State update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= 11'd0;
      command_match_mask <= '1;
      length_accumulator <= 10'd0;
      running_crc        <= CRC_INIT;
      hex_accumulator    <= 32'd0;
      digit_error_flag   <= 1'b0;
      frame_done         <= 1'b1;
      matched_command    <= 3'd0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      command_match_mask <= command_match_mask_next;
      length_accumulator <= length_accumulator_next;
      running_crc        <= running_crc_next;
      hex_accumulator    <= hex_accumulator_next;
      digit_error_flag   <= digit_error_flag_next;
      frame_done         <= frame_done_next;
      matched_command    <= matched_command_next;
    end
  end

endmodule

@@ rtl/ascii_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_command_frame_parser: ASCII command frame parser with CRC-32 check
// Parses framed ASCII commands byte by byte, passes payload bytes out and
// ends each frame that reaches an error or its END token with one status result.
// ----------------------------------------------------------------------------
// Usage:
//   byte_chan carries one message byte per transaction; frame_start marks the
//   first byte of a message and always restarts parsing at that byte. Bytes
//   with frame_start low are dropped while no frame is active.
//   result_chan carries a payload byte (result_kind 0) for every payload
//   byte of the frame, and one status result (result_kind 1) that closes the
//   frame at the first error or at the last byte of the END token.
//   Throughput is one byte per cycle unless result_chan stalls. A result
//   appears on result_chan in the cycle after the byte that causes it is
//   taken; a byte's CRC update, matching and field checks are combinational.
//   The result sits in an output register. byte_chan stays ready while that
//   register is empty or is being drained in the same cycle, so while a
//   result waits for a stalled receiver, byte_chan is held off for as long
//   as the stall lasts and nothing is lost.
//   After reset the parser is idle, waiting for a byte marked frame_start,
//   and result_chan is empty.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser
  import acfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  acfp_in_if.sink  byte_chan,
  acfp_out_if.source result_chan
);

  logic         accept;
  acfp_result_t res;

  // Output register.
  logic         out_valid;
  logic         out_kind;
  logic [7:0]   out_byte;
  acfp_status_t out_status;
  logic [2:0]   out_cmd;
  logic [9:0]   out_len;
  logic [31:0]  out_crc;

  // A byte is taken when the output register is free or being emptied.
  assign byte_chan.ready = !out_valid || result_chan.ready;
  assign accept          = byte_chan.valid && byte_chan.ready;

  acfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (byte_chan.data_byte),
    .frame_start (byte_chan.frame_start),
    .res         (res)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.valid;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each new result.
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_kind   <= res.result_kind;
      out_byte   <= res.payload_byte;
      out_status <= res.status;
      out_cmd    <= res.command_type;
      out_len    <= res.payload_length;
      out_crc    <= res.received_crc;
    end
  end

  assign result_chan.valid          = out_valid;
  assign result_chan.result_kind    = out_kind;
  assign result_chan.payload_byte   = out_byte;
  assign result_chan.status         = out_status;
  assign result_chan.command_type   = out_cmd;
  assign result_chan.payload_length = out_len;
  assign result_chan.received_crc   = out_crc;

  // A waiting result must block the input so it is never overwritten.
  a_block_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_chan.ready) |-> !byte_chan.ready)
    else $error("input taken while a result was stalled");

  // With the output register empty the input must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> byte_chan.ready)
    else $error("input blocked with an empty output register");

  // A payload result never carries a status code or a CRC value.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (result_chan.valid && result_chan.result_kind == KIND_PAYLOAD) |->
      (result_chan.status == ST_OK && result_chan.received_crc == 32'd0))
    else $error("payload result carries status fields");

  // A byte taken without a result leaves the output register empty or drained.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (accept && !res.valid) |=> !out_valid)
    else $error("result appeared without a causing byte");

endmodule

@@ tb/ascii_command_frame_parser_tb.sv @@
// ----------------------------------------------------------------------------
// ascii_command_frame_parser_tb: self-checking bench for the frame parser
// Drives message bytes through the input channel with random gaps and checks
// every payload byte and frame status against a cycle-free model of the
// parser that runs in the bench. A directed table covers the token errors,
// the field checks and the extremes, then random frames with random content
// and random damage exercise the rest.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser_tb
  import acfp_pkg::*;
();

  localparam int RANDOM_BYTES = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;

  // One expected or observed transaction on the result channel.
  typedef struct packed {
    logic         kind;
    logic [7:0]   data;
    acfp_status_t status;
    logic [2:0]   cmd;
    logic [9:0]   len;
    logic [31:0]  crc;
  } frame_result_t;

  // One byte to send; a typed row carries its own expected frame status.
  typedef struct packed {
    logic [7:0]    data;
    logic          start;
    logic          typed;
    frame_result_t want;
  } byte_plan_t;

  logic clk = 1'b0;
  logic rst;

  acfp_in_if  byte_if ();
  acfp_out_if res_if ();

  ascii_command_frame_parser dut (
    .clk        (clk),
    .rst        (rst),
    .byte_chan  (byte_if),
    .result_chan(res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored in the bench.
  logic [10:0] f_pos;
  logic [6:0]  f_mask;
  logic [9:0]  f_len;
  logic [31:0] f_crc;
  logic [31:0] f_hex;
  logic        f_bad;
  logic        f_idle;
  logic [2:0]  f_cmd;

  frame_result_t pending_results[$];
  byte_plan_t    byte_plan[$];
  logic [7:0]    frame_bytes[$];

  int   errors = 0;
  int   parsed_bytes = 0;
  int   payload_seen = 0;
  int   status_seen = 0;
  int   random_frames = 0;
  int   holds_done = 0;
  logic [8:0] codes_seen = '0;
  bit   no_gaps = 1'b0;
  bit   hold_req = 1'b0;

  // Reflected CRC-32, one message bit per step.
  function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c;
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ ((x[0] ^ b[i]) ? 32'hEDB88320 : 32'h0);
    end
    return x;
  endfunction

  function automatic void clear_parser();
    f_pos  = '0;
    f_mask = '1;
    f_len  = '0;
    f_crc  = '1;
    f_hex  = '0;
    f_bad  = 1'b0;
    f_idle = 1'b1;
    f_cmd  = '0;
  endfunction

  // Closes the frame with a status; fields not yet accepted read as zero.
  function automatic bit frame_status(input acfp_status_t code, input bit with_cmd,
                                      input bit with_len, input bit with_crc,
                                      output frame_result_t r);
    f_idle   = 1'b1;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = code;
    r.cmd    = with_cmd ? f_cmd : 3'd0;
    r.len    = with_len ? f_len : 10'd0;
    r.crc    = with_crc ? f_hex : 32'd0;
    return 1'b1;
  endfunction

  // Advances the parser by one byte and returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output frame_result_t r);
    int pos;
    int len;
    r = '0;
    if (st) begin
      clear_parser();
      f_idle = 1'b0;
    end
    if (f_idle) return 1'b0;
    pos = int'(f_pos);
    len = int'(f_len);

    if (pos < 6) begin
      // Start token.
      f_crc = crc32_feed(f_crc, b);
      if (b != START_TOK[pos]) return frame_status(ST_NO_START, 0, 0, 0, r);
    end else if (pos < 12) begin
      // Command name: drop every candidate that differs at this position.
      f_crc = crc32_feed(f_crc, b);
      for (int k = 0; k < NUM_CMDS; k++) begin
        if (CMD_NAMES[k][pos - 6] != b) f_mask[k] = 1'b0;
      end
      if (f_mask == '0) return frame_status(ST_UNKNOWN_CMD, 0, 0, 0, r);
      if (pos == 11) begin
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
          if (f_mask[k]) f_cmd = 3'(k);
        end
      end
    end else if (pos < 15) begin
      // Length digits; a bad digit is only remembered.
      f_crc = crc32_feed(f_crc, b);
      if (b >= "0" && b <= "9") f_len = 10'(f_len * 10 + (b - "0"));
      else f_bad = 1'b1;
    end else if (pos == 15) begin
      // Length terminator is judged before the digits.
      f_crc = crc32_feed(f_crc, b);
      if (b != CHAR_SEMI) return frame_status(ST_LEN_TERM, 1, 0, 0, r);
      if (f_bad) return frame_status(ST_LEN_DIGIT, 1, 0, 0, r);
    end else if (pos < 16 + len) begin
      // Payload byte goes straight out.
      f_crc  = crc32_feed(f_crc, b);
      f_pos  = 11'(pos + 1);
      r.kind = KIND_PAYLOAD;
      r.data = b;
      r.status = ST_OK;
      r.cmd  = f_cmd;
      r.len  = f_len;
      return 1'b1;
    end else if (pos == 16 + len) begin
      // Separator byte: unchecked but covered by the CRC.
      f_crc = crc32_feed(f_crc, b);
    end else if (pos < 25 + len) begin
      // CRC hex digits.
      if (b >= "0" && b <= "9") f_hex = {f_hex[27:0], 4'(b - "0")};
      else if (b >= "a" && b <= "f") f_hex = {f_hex[27:0], 4'(b - "a" + 8'd10)};
      else if (b >= "A" && b <= "F") f_hex = {f_hex[27:0], 4'(b - "A" + 8'd10)};
      else f_bad = 1'b1;
    end else if (pos == 25 + len) begin
      if (b != CHAR_SEMI) return frame_status(ST_CRC_TERM, 1, 1, 0, r);
      if (f_bad) return frame_status(ST_CRC_HEX, 1, 1, 0, r);
      if (~f_crc != f_hex) return frame_status(ST_CRC_MISMATCH, 1, 1, 1, r);
    end else begin
      // End token; the last byte closes a good frame.
      if (b != END_TOK[pos - (26 + len)]) return frame_status(ST_NO_END, 1, 1, 1, r);
      if (pos == 28 + len) return frame_status(ST_OK, 1, 1, 1, r);
    end
    f_pos = 11'(pos + 1);
    return 1'b0;
  endfunction

  // Stimulus builders.
  function automatic void queue_byte(input logic [7:0] b, input logic st);
    byte_plan_t p;
    p       = '0;
    p.data  = b;
    p.start = st;
    byte_plan.push_back(p);
  endfunction

  function automatic void queue_text(input string s, input logic st);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], st && (i == 0));
  endfunction

  function automatic void type_last(input acfp_status_t code, input int cmd, input int len,
                                    input logic [31:0] crc);
    int last;
    last = byte_plan.size() - 1;
    byte_plan[last].typed       = 1'b1;
    byte_plan[last].want        = '0;
    byte_plan[last].want.kind   = KIND_STATUS;
    byte_plan[last].want.status = code;
    byte_plan[last].want.cmd    = 3'(cmd);
    byte_plan[last].want.len    = 10'(len);
    byte_plan[last].want.crc    = crc;
  endfunction

  function automatic logic [7:0] hex_digit_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return 8'("0" + n);
    base = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return 8'(base + n - 8'd10);
  endfunction

  // Start token, command name, length field and random payload.
  function automatic void start_frame(input int cmd, input int plen);
    frame_bytes.delete();
    for (int i = 0; i < TOK_LEN; i++) frame_bytes.push_back(START_TOK[i]);
    for (int i = 0; i < TOK_LEN; i++) frame_bytes.push_back(CMD_NAMES[cmd][i]);
    frame_bytes.push_back(8'("0" + plen / 100));
    frame_bytes.push_back(8'("0" + (plen / 10) % 10));
    frame_bytes.push_back(8'("0" + plen % 10));
    frame_bytes.push_back(CHAR_SEMI);
    repeat (plen) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Separator, the matching CRC field and the end token.
  function automatic void close_frame();
    logic [31:0] c;
    c = '1;
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (frame_bytes[i]) c = crc32_feed(c, frame_bytes[i]);
    c = ~c;
    for (int i = 7; i >= 0; i--) frame_bytes.push_back(hex_digit_char(c[4*i +: 4]));
    frame_bytes.push_back(CHAR_SEMI);
    for (int i = 0; i < END_LEN; i++) frame_bytes.push_back(END_TOK[i]);
  endfunction

  function automatic void cut_frame(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endfunction

  function automatic void queue_frame();
    foreach (frame_bytes[i]) queue_byte(frame_bytes[i], i == 0);
  endfunction

  // Sends one byte after a random gap and records what it should produce.
  task automatic send_byte(input byte_plan_t p);
    int            gap;
    bit            got;
    bit            busy;
    frame_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= p.data;
    byte_if.frame_start <= p.start;
    do @(posedge clk); while (!byte_if.ready);
    busy = !f_idle || p.start;
    got  = parse_byte(p.data, p.start, r);
    if (p.typed) begin
      r   = p.want;
      got = 1'b1;
    end
    if (got) pending_results.push_back(r);
    if (busy) parsed_bytes++;
  endtask

  task automatic send_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d status %0d", res_if.result_kind, res_if.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, res_if.result_kind);
        check_field("payload_byte", want.data, res_if.payload_byte);
        check_field("status", want.status, res_if.status);
        check_field("command_type", want.cmd, res_if.command_type);
        check_field("payload_length", want.len, res_if.payload_length);
        check_field("received_crc", want.crc, res_if.received_crc);
      end
      if (res_if.result_kind == KIND_PAYLOAD) begin
        payload_seen++;
      end else begin
        status_seen++;
        if (res_if.status <= ST_NO_END) codes_seen[res_if.status] = 1'b1;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin : result_receiver
    int wait_n;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      wait_n = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        wait_n += HOLD_CYCLES;
        hold_req = 1'b0;
        holds_done++;
      end
      if (wait_n > 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  initial begin : stall_watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) stall = 0;
      else stall++;
    end
    $display("** ascii_command_frame_parser: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed table, random frames, drain and verdict.
  initial begin : main_sequence
    int plen;
    int idx;
    rst                 = 1'b1;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = '0;
    byte_if.frame_start = 1'b0;
    clear_parser();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed table. Bytes without a start mark are dropped while idle.
    queue_text("ZZ", 1'b0);
    queue_text("STARX", 1'b1);
    type_last(ST_NO_START, 0, 0, 32'h0);
    queue_byte(8'h00, 1'b1);
    type_last(ST_NO_START, 0, 0, 32'h0);
    queue_byte(8'hFF, 1'b1);
    type_last(ST_NO_START, 0, 0, 32'h0);
    queue_text("START;SHUTX", 1'b1);
    type_last(ST_UNKNOWN_CMD, 0, 0, 32'h0);
    queue_text("START;Q", 1'b1);
    type_last(ST_UNKNOWN_CMD, 0, 0, 32'h0);
    queue_text("START;RINIT;123:", 1'b1);
    type_last(ST_LEN_TERM, 1, 0, 32'h0);
    queue_text("START;DCONF;1a3;", 1'b1);
    type_last(ST_LEN_DIGIT, 2, 0, 32'h0);
    // A bad digit and a bad terminator together: the terminator wins.
    queue_text("START;CONNC;4x5:", 1'b1);
    type_last(ST_LEN_TERM, 3, 0, 32'h0);
    // Frame cut off by a new start gives no status of its own.
    queue_text("START;ASY", 1'b1);
    for (int c = 0; c < NUM_CMDS; c++) begin
      start_frame(c, c);
      close_frame();
      queue_frame();
    end
    start_frame(4, 2);
    frame_bytes[16] = 8'h00;
    frame_bytes[17] = 8'hFF;
    close_frame();
    queue_frame();
    start_frame(5, 1);
    close_frame();
    frame_bytes[26] = ":";
    cut_frame(27);
    queue_frame();
    type_last(ST_CRC_TERM, 5, 1, 32'h0);
    start_frame(0, 0);
    close_frame();
    frame_bytes[20] = "g";
    cut_frame(26);
    queue_frame();
    type_last(ST_CRC_HEX, 0, 0, 32'h0);
    start_frame(1, 4);
    close_frame();
    for (int i = 21; i <= 28; i++) frame_bytes[i] = "F";
    cut_frame(30);
    queue_frame();
    type_last(ST_CRC_MISMATCH, 1, 4, 32'hFFFFFFFF);
    start_frame(2, 0);
    close_frame();
    for (int i = 17; i <= 24; i++) frame_bytes[i] = "0";
    cut_frame(26);
    queue_frame();
    type_last(ST_CRC_MISMATCH, 2, 0, 32'h0);
    start_frame(3, 0);
    close_frame();
    frame_bytes[27] = "X";
    cut_frame(28);
    queue_frame();
    queue_text("D", 1'b0);
    start_frame(6, 999);
    close_frame();
    queue_frame();
    // The receiver holds off for a long stretch while the table is still being sent.
    hold_req = 1'b1;
    send_plan();

    // Random frames: mostly well formed, some damaged, cut short or mixed with noise.
    parsed_bytes = 0;
    while (parsed_bytes < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 11) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      start_frame($urandom_range(0, NUM_CMDS - 1), plen);
      close_frame();
      case ($urandom_range(0, 9))
        5, 6: begin
          idx = $urandom_range(0, frame_bytes.size() - 1);
          frame_bytes[idx] = 8'($urandom_range(0, 255));
        end
        7: begin
          idx = $urandom_range(17 + plen, 24 + plen);
          frame_bytes[idx] = hex_digit_char(4'($urandom_range(0, 15)));
        end
        8: cut_frame($urandom_range(1, frame_bytes.size() - 1));
        9: begin
          idx = $urandom_range(frame_bytes.size() - 12, frame_bytes.size() - 1);
          frame_bytes[idx] = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      queue_frame();
      send_plan();
      random_frames++;
    end

    // Drain the outstanding results, then allow for the output register.
    no_gaps = 1'b0;
    @(negedge clk);
    byte_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d payload bytes and %0d frame statuses over %0d random frames",
             payload_seen, status_seen, random_frames);
    $display("Status codes seen (one bit per code, ok in bit 0): %b, long hold-offs: %0d",
             codes_seen, holds_done);
    if (errors == 0) $display("** ascii_command_frame_parser: PASSED **");
    else $display("** ascii_command_frame_parser: FAILED **");
    $finish;
  end

endmodule

@@ ascii_command_frame_parser.f @@
rtl/acfp_pkg.sv
rtl/acfp_in_if.sv
rtl/acfp_out_if.sv
rtl/acfp_parser.sv
rtl/ascii_command_frame_parser.sv
tb/ascii_command_frame_parser_tb.sv
